[rtl/rcfe_pkg.sv]
// Shared widths, register indexes and the key table for the rolling code frame encryptor.
package rcfe_pkg;

   localparam int CodeWidth   = 16;
   localparam int RepeatWidth = 4;
   localparam int SerialWidth = 28;
   localparam int ButtonWidth = 4;
   localparam int FrameWidth  = 52;
   localparam int CsrIdxWidth = 4;
   localparam int CsrDatWidth = 32;
   localparam int KeyDepth    = 32;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_DEVICE_SERIAL = 4'd0,
      CSR_BUTTON_ID     = 4'd1
   } csr_index_type;

   typedef logic [5:0][7:0] cipher_bytes_type;

   localparam logic [7:0] KeyTable [KeyDepth] = '{
      8'd25,  8'd5,   8'd63,  8'd97,  8'd203, 8'd109, 8'd69,  8'd10,
      8'd3,   8'd7,   8'd64,  8'd5,   8'd71,  8'd134, 8'd180, 8'd74,
      8'd41,  8'd158, 8'd102, 8'd199, 8'd93,  8'd118, 8'd175, 8'd101,
      8'd60,  8'd77,  8'd143, 8'd174, 8'd103, 8'd148, 8'd29,  8'd85
   };

   localparam logic [7:0] KeyOffset   = 8'h25;
   localparam logic [7:0] FoldHiMask  = 8'hE0;
   localparam logic [7:0] FoldLoMask  = 8'h07;
   localparam logic [3:0] RepeatFlip  = 4'hF;

endpackage

[rtl/rcfe_if.sv]
// Handshake channel interfaces for requests, responses and register writes.
interface rcfe_req_if import rcfe_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CodeWidth-1:0]   rolling_code;
   logic [RepeatWidth-1:0] repeat_index;

   modport source (output valid, output rolling_code, output repeat_index, input ready);
   modport sink   (input valid, input rolling_code, input repeat_index, output ready);
endinterface

interface rcfe_rsp_if import rcfe_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [FrameWidth-1:0] frame_bits;

   modport source (output valid, output frame_bits, input ready);
   modport sink   (input valid, input frame_bits, output ready);
endinterface

interface rcfe_csr_if import rcfe_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CsrIdxWidth-1:0] index;
   logic [CsrDatWidth-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/rolling_code_frame_encrypt.sv]
// Rolling code frame encryptor: two-round keyed obfuscation and radio frame assembly.
// An accepted request goes to the input register, then its frame to the result register.
// One item per cycle unless the response stalls; the cipher sits between the registers.
// A stalled response holds the result register, and the input register behind it.
// Reset (synchronous, active high) empties both stages and clears serial and button to 0.
// The register port always accepts; writes to an unknown index are dropped.
module rolling_code_frame_encrypt import rcfe_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   rcfe_req_if.sink     req_chan,
   rcfe_rsp_if.source   rsp_chan,
   rcfe_csr_if.sink     csr_chan
);

   // configuration registers
   logic [SerialWidth-1:0] serial_ff;
   logic [ButtonWidth-1:0] button_ff;

   // input stage
   logic                   in_valid_ff;
   logic [CodeWidth-1:0]   code_ff;
   logic [RepeatWidth-1:0] repeat_ff;

   // result stage
   logic                   out_valid_ff;
   logic [FrameWidth-1:0]  frame_ff;
   logic [FrameWidth-1:0]  frame_in;

   logic out_open;
   logic in_open;

   // One keyed half step: look up the key, xor it into the upper bytes,
   // keep byte 5 a nibble and fold part of the key into byte 0.
   function automatic cipher_bytes_type half_step(cipher_bytes_type b, logic second);
      logic [7:0]       key;
      cipher_bytes_type r;
      if (second) begin
         key = KeyTable[b[0][7:3]] + KeyOffset;
      end else begin
         key = KeyTable[b[0][4:0]];
      end
      r = b;
      for (int i = 1; i < 6; i++) begin
         r[i] = b[i] ^ key;
      end
      r[5] = {4'h0, r[5][3:0]};
      r[0] = b[0] ^ (key & (second ? FoldLoMask : FoldHiMask));
      return r;
   endfunction

   // The result stage opens when it is empty or its item is taken;
   // the input stage opens when it is empty or its item moves on.
   assign out_open = !out_valid_ff || rsp_chan.ready;
   assign in_open  = !in_valid_ff || out_open;

   assign req_chan.ready   = in_open;
   assign csr_chan.ready   = 1'b1;
   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.frame_bits = frame_ff;

   // cipher and frame assembly
   always_comb begin
      cipher_bytes_type b;
      cipher_bytes_type s;
      logic [7:0]       tmp;
      b[0] = code_ff[7:0];
      b[1] = code_ff[15:8];
      b[2] = serial_ff[7:0];
      b[3] = serial_ff[15:8];
      b[4] = serial_ff[23:16];
      b[5] = {4'h0, serial_ff[27:24]};

      // first round, then swap bytes 0 and 1
      b   = half_step(b, 1'b0);
      b   = half_step(b, 1'b1);
      tmp  = b[0];
      b[0] = b[1];
      b[1] = tmp;

      // second round
      b = half_step(b, 1'b0);
      b = half_step(b, 1'b1);

      // inverting shuffle
      s[5] = {4'h0, ~b[5][3:0]};
      s[4] = ~b[0];
      s[0] = ~b[2];
      s[2] = ~b[4];
      s[3] = ~b[1];
      s[1] = ~b[3];

      frame_in = {button_ff, repeat_ff ^ button_ff ^ RepeatFlip, s[5][3:0],
                  s[4], s[3], s[2], s[1], s[0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         serial_ff    <= '0;
         button_ff    <= '0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         // register writes; unknown indexes drop
         if (csr_chan.valid) begin
            unique case (csr_chan.index)
               CSR_DEVICE_SERIAL: serial_ff <= csr_chan.data[SerialWidth-1:0];
               CSR_BUTTON_ID:     button_ff <= csr_chan.data[ButtonWidth-1:0];
               default: ;
            endcase
         end
         // advance the input stage
         if (in_open) begin
            in_valid_ff <= req_chan.valid;
         end
         // advance the result stage
         if (out_open) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (in_open && req_chan.valid) begin
         code_ff   <= req_chan.rolling_code;
         repeat_ff <= req_chan.repeat_index;
      end
      if (out_open && in_valid_ff) begin
         frame_ff <= frame_in;
      end
   end

endmodule
